### rtl/core/gvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gvt_pkg: shared definitions of the growable vector table
// default sizes, command and status codes, result layout
// ----------------------------------------------------------------------------
package gvt_pkg;

    localparam int DEF_DEPTH            = 256;
    localparam int DEF_INITIAL_CAPACITY = 4;
    localparam int DEF_DATA_WIDTH       = 32;

    // fixed field widths of the streaming channels
    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 9;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_READ   = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_t;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // packed from the msb down, so read_value lands in the lowest bits
    typedef struct packed {
        logic              resized;
        logic [CNT_W-1:0]  capacity_now;
        logic [CNT_W-1:0]  element_count;
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  read_value;
    } result_t;

endpackage : gvt_pkg
`default_nettype wire

### rtl/core/gvt_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gvt_store: element storage
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module gvt_store #(
    parameter int DEPTH = gvt_pkg::DEF_DEPTH,
    parameter int SW    = gvt_pkg::DEF_DATA_WIDTH,
    parameter int AW    = $clog2(gvt_pkg::DEF_DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [SW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [SW-1:0] rdata
);
    import gvt_pkg::*;

    logic [SW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule : gvt_store
`default_nettype wire

### rtl/core/growable_vector_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// growable_vector_table: indexed element table with doubling/halving capacity
// append, read, write and remove at an index; remove closes the gap
// ----------------------------------------------------------------------------
// One command per input transfer, one result per command. Append, write and
// any refused command finish in the idle state. A read waits in ST_READ for the
// registered read data of the element memory. A remove at index p moves every
// element above p down one place in ST_SHIFT; the memory moves one element
// down per cycle, writing entry i with the element fetched the cycle before
// while fetching entry i+2. A new command is taken while a result still
// waits on the master side, as long as no read or remove is in progress and
// the output register is free or being drained in the same cycle. The element
// memory is not cleared after reset; entries are only read inside the count.
module growable_vector_table #(
    parameter int DEPTH            = gvt_pkg::DEF_DEPTH,
    parameter int INITIAL_CAPACITY = gvt_pkg::DEF_INITIAL_CAPACITY,
    parameter int DATA_WIDTH       = gvt_pkg::DEF_DATA_WIDTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input command channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // position[7:0], item_value[39:8]
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // read_value[31:0], status[33:32],
                                        // element_count[42:34],
                                        // capacity_now[51:43], resized[52]
);
    import gvt_pkg::*;

    // storage width: the data path never carries more than the port width
    localparam int SW = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // count and capacity width, at least wide enough for the result fields
    localparam int CW = ($clog2(DEPTH + 1) > CNT_W) ? $clog2(DEPTH + 1) : CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT
    } state_t;

    state_t        state_reg,    state_next;
    logic [CW-1:0] count_reg,    count_next;
    logic [CW-1:0] cap_reg,      cap_next;
    logic [AW-1:0] wr_ptr_reg,   wr_ptr_next;
    logic          out_valid_reg, out_valid_next;
    result_t       result_reg,   result_next;

    // memory side
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [SW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [SW-1:0] mem_rdata;

    // command fields
    cmd_t          cmd;
    logic [CW-1:0] pos_ext;
    logic [SW-1:0] item_data;
    logic          accept;

    // helpers
    logic [CW:0]   cap_dbl;
    logic [CW-1:0] cap_grown;
    logic [CW-1:0] pos_plus1;
    logic [CW-1:0] ptr_plus2;
    logic [CW-1:0] rm_count;
    logic          rm_halve;

    assign cmd       = cmd_t'(s_tuser);
    assign pos_ext   = CW'(s_tdata[POS_W-1:0]);
    assign item_data = s_tdata[POS_W +: SW];

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, result_reg};

    // doubled capacity, capped at the physical depth
    assign cap_dbl   = {cap_reg, 1'b0};
    assign cap_grown = (cap_dbl > (CW + 1)'(DEPTH)) ? CW'(DEPTH) : cap_dbl[CW-1:0];

    assign pos_plus1 = pos_ext + CW'(1);
    assign ptr_plus2 = CW'(wr_ptr_reg) + CW'(2);

    // count after a remove and the quarter-full halving test
    assign rm_count = count_reg - CW'(1);
    assign rm_halve = (rm_count != '0) && (rm_count == (cap_reg >> 2));

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        wr_ptr_next    = wr_ptr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        result_next    = result_reg;
        mem_we         = 1'b0;
        mem_waddr      = wr_ptr_reg;
        mem_wdata      = mem_rdata;
        mem_raddr      = pos_ext[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    result_next.read_value    = '0;
                    result_next.status        = STAT_DONE;
                    result_next.resized       = 1'b0;
                    result_next.element_count = count_reg[CNT_W-1:0];
                    result_next.capacity_now  = cap_reg[CNT_W-1:0];
                    out_valid_next            = 1'b1;

                    if (cmd == CMD_APPEND) begin
                        if (count_reg >= CW'(DEPTH)) begin
                            result_next.status = STAT_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            mem_wdata  = item_data;
                            count_next = count_reg + CW'(1);
                            result_next.element_count = count_next[CNT_W-1:0];
                            if (count_reg >= cap_reg) begin
                                cap_next            = cap_grown;
                                result_next.resized = 1'b1;
                            end
                            result_next.capacity_now = cap_next[CNT_W-1:0];
                        end
                    end else if (pos_ext >= count_reg) begin
                        // index outside the count, nothing changes
                        result_next.status = STAT_RANGE;
                    end else begin
                        unique case (cmd)
                            CMD_READ: begin
                                // data comes back next cycle
                                out_valid_next = 1'b0;
                                state_next     = ST_READ;
                            end
                            CMD_WRITE: begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_ext[AW-1:0];
                                mem_wdata = item_data;
                            end
                            CMD_REMOVE: begin
                                if (pos_plus1 < count_reg) begin
                                    // fetch the first element to move down
                                    mem_raddr      = pos_plus1[AW-1:0];
                                    wr_ptr_next    = pos_ext[AW-1:0];
                                    out_valid_next = 1'b0;
                                    state_next     = ST_SHIFT;
                                end else begin
                                    // last element removed, no move needed
                                    count_next = rm_count;
                                    result_next.element_count = rm_count[CNT_W-1:0];
                                    if (rm_halve) begin
                                        cap_next            = cap_reg >> 1;
                                        result_next.resized = 1'b1;
                                    end
                                    result_next.capacity_now = cap_next[CNT_W-1:0];
                                end
                            end
                            default: begin
                                // append handled above
                            end
                        endcase
                    end
                end
            end

            ST_READ: begin
                result_next.read_value = VAL_W'(mem_rdata);
                out_valid_next         = 1'b1;
                state_next             = ST_IDLE;
            end

            ST_SHIFT: begin
                // move the fetched element down one place
                mem_we    = 1'b1;
                mem_waddr = wr_ptr_reg;
                mem_wdata = mem_rdata;
                if (ptr_plus2 < count_reg) begin
                    mem_raddr   = ptr_plus2[AW-1:0];
                    wr_ptr_next = wr_ptr_reg + AW'(1);
                end else begin
                    count_next                = rm_count;
                    result_next.read_value    = '0;
                    result_next.status        = STAT_DONE;
                    result_next.element_count = rm_count[CNT_W-1:0];
                    result_next.resized       = rm_halve;
                    if (rm_halve) begin
                        cap_next = cap_reg >> 1;
                    end
                    result_next.capacity_now  = cap_next[CNT_W-1:0];
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= CW'(INITIAL_CAPACITY);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
        // payload, no reset needed
        wr_ptr_reg <= wr_ptr_next;
        result_reg <= result_next;
    end

    gvt_store #(
        .DEPTH (DEPTH),
        .SW    (SW),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule : growable_vector_table
`default_nettype wire
